// File: rtl/b2da_pkg.sv
package b2da_pkg;

  localparam int DIGIT_W = 4;
  localparam int CHAR_W  = 6;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [CHAR_W-1:0]  char_t;

  localparam char_t ASCII_ZERO = 6'd48;
  localparam char_t ASCII_NINE = 6'd57;

  localparam digit_t DIGIT_FIVE  = 4'd5;
  localparam digit_t DIGIT_THREE = 4'd3;

endpackage

// File: rtl/b2da_front.sv
module b2da_front import b2da_pkg::*; #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [63:0]            value,
  output logic                   busy,
  output logic                   q_valid,
  output logic [VALUE_WIDTH-1:0] q_value,
  input  logic                   q_pop
);

  localparam int DEPTH = 2;

  logic [VALUE_WIDTH-1:0] entry [DEPTH];
  logic                   wr_ptr;
  logic                   rd_ptr;
  logic [1:0]             count;
  logic                   push;

  assign busy    = (count == 2'(DEPTH));
  assign push    = start && !busy;
  assign q_valid = (count != 2'd0);
  assign q_value = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= value[VALUE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !q_pop) begin
        count <= count + 2'd1;
      end else if (!push && q_pop) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// File: rtl/b2da_back.sv
module b2da_back import b2da_pkg::*; #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  logic [VALUE_WIDTH-1:0] q_value,
  output logic                   q_pop,
  output logic                   strobe,
  output logic [5:0]             digit_char,
  output logic                   last
);

  // decimal digits of 2**VALUE_WIDTH - 1
  localparam int NDIG   = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int BCD_W  = DIGIT_W * NDIG;
  localparam int CNT_W  = $clog2(VALUE_WIDTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]             state;
  logic [VALUE_WIDTH-1:0] shreg;
  logic [BCD_W-1:0]       bcd;
  logic [BCD_W-1:0]       bcd_adj;
  logic [CNT_W-1:0]       cnt;
  logic                   started;
  digit_t                 top;
  logic                   emit;

  assign q_pop = (state == ST_IDLE) && q_valid;
  assign top   = bcd[BCD_W-1 -: DIGIT_W];
  assign emit  = started || (top != digit_t'(0)) || (cnt == '0);

  always_comb begin
    digit_t d;
    for (int i = 0; i < NDIG; i++) begin
      d = bcd[i*DIGIT_W +: DIGIT_W];
      bcd_adj[i*DIGIT_W +: DIGIT_W] = (d >= DIGIT_FIVE) ? d + DIGIT_THREE : d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      strobe  <= 1'b0;
      started <= 1'b0;
      cnt     <= '0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            shreg   <= q_value;
            bcd     <= '0;
            cnt     <= CNT_W'(VALUE_WIDTH - 1);
            started <= 1'b0;
            state   <= ST_CONV;
          end
        end
        ST_CONV: begin
          bcd   <= {bcd_adj[BCD_W-2:0], shreg[VALUE_WIDTH-1]};
          shreg <= {shreg[VALUE_WIDTH-2:0], 1'b0};
          if (cnt == '0) begin
            cnt   <= CNT_W'(NDIG - 1);
            state <= ST_EMIT;
          end else begin
            cnt   <= cnt - CNT_W'(1);
          end
        end
        ST_EMIT: begin
          if (emit) begin
            strobe     <= 1'b1;
            digit_char <= ASCII_ZERO + {2'b00, top};
            last       <= (cnt == '0);
            started    <= 1'b1;
          end
          bcd <= {bcd[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
          cnt <= cnt - CNT_W'(1);
          if (cnt == '0) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/binary_to_decimal_ascii.sv
// Channel  | Ports                          | Handshake
// ---------+--------------------------------+------------------------------
// input    | start, busy, value             | item taken on start && !busy
// result   | strobe, digit_char, last       | chars of a run back to back, no stall
//
// In the converter an item takes a load step, then one shift-add-3 step per input
// bit, then one emit step per digit position, leading zeros skipped silently;
// NDIG is 20 at VALUE_WIDTH = 64.
// A two-entry queue sits in front of the converter; busy is high while it is full.
// Synchronous reset empties the queue and idles the converter.
// Results cannot be held off by the receiver.
module binary_to_decimal_ascii import b2da_pkg::*; #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] value,
  output logic        busy,
  output logic        strobe,
  output logic [5:0]  digit_char,
  output logic        last
);

  logic                   q_valid;
  logic [VALUE_WIDTH-1:0] q_value;
  logic                   q_pop;

  b2da_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .value   (value),
    .busy    (busy),
    .q_valid (q_valid),
    .q_value (q_value),
    .q_pop   (q_pop)
  );

  b2da_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_value    (q_value),
    .q_pop      (q_pop),
    .strobe     (strobe),
    .digit_char (digit_char),
    .last       (last)
  );

endmodule

// File: rtl/b2da_checker.sv
module b2da_checker import b2da_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       busy,
  input logic       strobe,
  input logic [5:0] digit_char,
  input logic       last
);

  // digits of a run leave on consecutive cycles
  a_run_contiguous: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> strobe)
    else $error("gap inside a digit run");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (digit_char >= ASCII_ZERO) && (digit_char <= ASCII_NINE))
    else $error("result is not a decimal digit");

  // a run only starts with '0' when the value is zero
  a_no_leading_zero: assert property (@(posedge clk) disable iff (rst)
    strobe && !($past(strobe) && !$past(last)) && (digit_char == ASCII_ZERO) |-> last)
    else $error("leading zero emitted");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !busy && !strobe)
    else $error("not idle after reset");

endmodule

bind binary_to_decimal_ascii b2da_checker u_chk (.*);

// File: tb/sv/binary_to_decimal_ascii_test.sv
module binary_to_decimal_ascii_test;
  import b2da_pkg::*;

  localparam int VALUE_WIDTH = 64;
  localparam logic [63:0] VALUE_MASK = ~64'd0 >> (64 - VALUE_WIDTH);
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = VALUE_WIDTH + 20 + 16;

  typedef struct packed {
    char_t ch;
    logic  last;
  } digit_rec_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic [63:0] value;
  logic        busy;
  logic        strobe;
  logic [5:0]  digit_char;
  logic        last;

  digit_rec_t digits_due[$];
  int values_sent = 0;
  int chars_seen = 0;
  int error_count = 0;
  int idle_cycles = 0;

  binary_to_decimal_ascii #(.VALUE_WIDTH(VALUE_WIDTH)) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .value(value),
    .busy(busy),
    .strobe(strobe),
    .digit_char(digit_char),
    .last(last)
  );

  always #4 clk = ~clk;

  // Expected characters of one value, most significant digit first.
  function automatic void queue_decimal_digits(input logic [63:0] raw);
    logic [63:0] v;
    digit_t      digs[20];
    int          n;
    digit_rec_t  rec;
    v = raw & VALUE_MASK;
    n = 0;
    do begin
      digs[n] = digit_t'(v % 64'd10);
      v = v / 64'd10;
      n++;
    end while (v != 64'd0 && n < 20);
    for (int k = n - 1; k >= 0; k--) begin
      rec.ch = ASCII_ZERO + char_t'(digs[k]);
      rec.last = (k == 0);
      digits_due.push_back(rec);
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 90);
  endfunction

  function automatic logic [63:0] random_value();
    logic [63:0] v;
    int          nbits;
    v = {$urandom, $urandom};
    nbits = $urandom_range(1, 64);
    return v >> (64 - nbits);
  endfunction

  // Leaves start high after the item is taken, so a zero gap runs back to back.
  task automatic send_value(input logic [63:0] v, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      value <= {$urandom, $urandom};
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    value <= v;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    queue_decimal_digits(v);
    values_sent++;
  endtask

  task automatic run_directed_values();
    logic [63:0] picks[20];
    picks = '{
      64'd0, 64'd1, 64'd9, 64'd10, 64'd99, 64'd100, 64'd101,
      64'd4294967295, 64'd1234567890,
      64'd999999999999999999, 64'd1000000000000000000,
      64'd9999999999999999999, 64'd10000000000000000000,
      64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
      64'd18446744073709551614, 64'd18446744073709551615,
      64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 64'd0
    };
    foreach (picks[i]) send_value(picks[i], pick_gap());
  endtask

  task automatic run_random_values(input int count);
    repeat (count) send_value(random_value(), pick_gap());
  endtask

  // Keeps start high to fill the input queue and exercise busy.
  task automatic run_back_to_back(input int count);
    repeat (count) send_value(random_value(), 0);
  endtask

  task automatic run_sparse_traffic(input int count);
    repeat (count) begin
      if ($urandom_range(0, 3) == 0) send_value(random_value(), $urandom_range(40, 90));
      else send_value({$urandom, $urandom}, $urandom_range(0, 2));
    end
  endtask

  always @(posedge clk) begin
    digit_rec_t want;
    if (!rst) begin
      if ((start && !busy) || strobe) idle_cycles = 0;
      else idle_cycles++;
      if (strobe) begin
        chars_seen++;
        if (digits_due.size() == 0) begin
          $display("%0t: unexpected char: expected none, got char %0d last %0b",
                   $time, digit_char, last);
          error_count++;
        end else begin
          want = digits_due.pop_front();
          if (digit_char !== want.ch || last !== want.last) begin
            $display("%0t: char mismatch: expected char %0d last %0b, got char %0d last %0b",
                     $time, want.ch, want.last, digit_char, last);
            error_count++;
          end
        end
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout with %0d chars outstanding", $time, digits_due.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    value = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed_values();
    run_random_values(100);
    run_back_to_back(30);
    run_sparse_traffic(30);
    start <= 1'b0;
    while (digits_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Converted %0d values (directed, random widths, back to back, sparse)",
             values_sent);
    $display("Checked %0d digit chars, %0d errors", chars_seen, error_count);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
